/* sv/tga_rle_pixel_decoder_assert.svh */
// Assertion macros for the TGA pixel decoder; expects clk and rst_n in scope.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// Condition that must hold at every edge outside reset.
`define TGA_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger this edge implies condition at the next edge.
`define TGA_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* sv/tga_pkg.sv */
// Shared types, codes and helpers of the TGA pixel decoder.
package tga_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
    localparam int PAL_DW      = 24;

    typedef logic [2:0] fmt_t;

    localparam fmt_t FMT_INDEXED    = 3'd0;
    localparam fmt_t FMT_RGB16      = 3'd1;
    localparam fmt_t FMT_BGR24      = 3'd2;
    localparam fmt_t FMT_BGRA32     = 3'd3;
    localparam fmt_t FMT_GRAY8      = 3'd4;
    localparam fmt_t FMT_GRAY_ALPHA = 3'd5;

    localparam logic REQ_PIXEL   = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_PIXEL_FORMAT = 2'd0;
    localparam reg_idx_t REG_RLE_ENABLE   = 2'd1;
    localparam reg_idx_t REG_PIXEL_COUNT  = 2'd2;

    localparam fmt_t        FMT_RESET   = FMT_BGR24;
    localparam logic [31:0] COUNT_RESET = 32'd1;

    typedef struct packed {
        fmt_t        pixel_format;
        logic        rle_enable;
        logic [31:0] pixel_count;
    } cfg_t;

    // One finished pixel beat handed from the stream parser to the output stage.
    typedef struct packed {
        logic        valid;
        fmt_t        fmt;
        logic [31:0] word;
        logic        pal_hit;
        logic [7:0]  rep;
        logic        done;
    } px_info_t;

    function automatic logic [2:0] bytes_per_pixel(input fmt_t fmt);
        logic [2:0] n;
        case (fmt)
            FMT_INDEXED, FMT_GRAY8:    n = 3'd1;
            FMT_RGB16, FMT_GRAY_ALPHA: n = 3'd2;
            FMT_BGRA32:                n = 3'd4;
            default:                   n = 3'd3;
        endcase
        return n;
    endfunction

endpackage

/* sv/tga_if.sv */
// Channel interfaces of the TGA pixel decoder: byte input, pixel output, config writes.
interface tga_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;

    modport source (output valid, req_type, data_byte, palette_index, palette_color,
                    input ready);
    modport sink   (input valid, req_type, data_byte, palette_index, palette_color,
                    output ready);
endinterface

interface tga_px_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;

    modport source (output valid, red, green, blue, alpha, repeat_count, image_done,
                    input ready);
    modport sink   (input valid, red, green, blue, alpha, repeat_count, image_done,
                    output ready);
endinterface

interface tga_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tga_rle_pixel_decoder.sv */
// TGA pixel-data decoder, raw or RLE, with a 256-entry palette.
//
// pix_in carries one beat per stream byte (req_type pixel) or one palette
// entry write (req_type palette). pix_out carries one RGBA pixel with a
// repeat count; a run packet gives one beat with its count, clipped to the
// pixels left in the image. cfg writes pixel_format, rle_enable and
// pixel_count (index 0..2); cfg.ready is always high, write only when idle.
// Output: the byte that completes a pixel shows on pix_out in the cycle after
// it is taken; the palette read of indexed data fills that same cycle.
// Throughput: one input beat per cycle while pix_in.ready is high, set by the
// single palette read port and the one-entry output stage. Header bytes,
// partial-pixel bytes and palette writes give no output beat.
// Stall: pix_in.ready is high while the output stage is empty or being
// drained, so a stalled receiver holds one pixel and back-pressures input.
// Reset: stream state clears, registers take bgr24 / raw / count 1; palette
// contents are undefined until written.
module tga_rle_pixel_decoder
    import tga_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    tga_in_if.sink     pix_in,
    tga_px_if.source   pix_out,
    tga_cfg_if.sink    cfg
);

    `include "tga_rle_pixel_decoder_assert.svh"

    cfg_t     cfg_reg, cfg_next;
    px_info_t issue;
    logic     in_accept;
    logic     pixel_beat;
    logic     pixel_load;
    logic     pal_we;
    logic [PAL_DW-1:0] pal_rdata;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_PIXEL_FORMAT: cfg_next.pixel_format = cfg.data[2:0];
                REG_RLE_ENABLE:   cfg_next.rle_enable   = cfg.data[0];
                REG_PIXEL_COUNT:  cfg_next.pixel_count  = cfg.data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format <= FMT_RESET;
            cfg_reg.rle_enable   <= 1'b0;
            cfg_reg.pixel_count  <= COUNT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign pix_in.ready = !pix_out.valid || pix_out.ready;
    assign in_accept    = pix_in.valid && pix_in.ready;
    assign pixel_beat   = in_accept && (pix_in.req_type == REQ_PIXEL);
    assign pixel_load   = pixel_beat && issue.valid;
    assign pal_we       = in_accept && (pix_in.req_type == REQ_PALETTE) &&
                          (32'(pix_in.palette_index) < 32'(PAL_ENTRIES));

    tga_stream_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .beat_en   (pixel_beat),
        .data_byte (pix_in.data_byte),
        .issue     (issue)
    );

    tga_pal_ram #(
        .DEPTH (PAL_ENTRIES),
        .AW    (PAL_AW),
        .DW    (PAL_DW)
    ) u_pal (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pix_in.palette_index[PAL_AW-1:0]),
        .wdata (pix_in.palette_color[PAL_DW-1:0]),
        .re    (pixel_load),
        .raddr (issue.word[PAL_AW-1:0]),
        .rdata (pal_rdata)
    );

    tga_px_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (pixel_load),
        .pop          (pix_out.valid && pix_out.ready),
        .issue        (issue),
        .pal_rdata    (pal_rdata),
        .valid        (pix_out.valid),
        .red          (pix_out.red),
        .green        (pix_out.green),
        .blue         (pix_out.blue),
        .alpha        (pix_out.alpha),
        .repeat_count (pix_out.repeat_count),
        .image_done   (pix_out.image_done)
    );

    `TGA_ASSERT_NOW(a_rep_nonzero, !pix_out.valid || pix_out.repeat_count != 8'd0, "zero repeat count on output beat")
    `TGA_ASSERT_NOW(a_ready_when_empty, pix_out.valid || pix_in.ready, "input stalled with empty output stage")
    `TGA_ASSERT_NEXT(a_pixel_lands, pixel_load, pix_out.valid, "completed pixel did not reach output")
    `TGA_ASSERT_NEXT(a_pal_write_silent, pal_we && !pix_out.valid, !pix_out.valid, "palette write produced a pixel")

endmodule

/* sv/tga_pal_ram.sv */
// Palette memory: one write port, one read port, registered read data.
module tga_pal_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 24
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/tga_stream_ctl.sv */
// Stream parser: packet headers, byte assembly, run clipping and image pixel count.
module tga_stream_ctl
    import tga_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       beat_en,
    input  logic [7:0] data_byte,
    output px_info_t   issue
);

    logic        expect_header_reg, expect_header_next;
    logic        packet_is_run_reg, packet_is_run_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [23:0] pixel_bytes_reg, pixel_bytes_next;
    logic [31:0] pixels_left_reg, pixels_left_next;

    logic [31:0] pl_eff;
    logic [2:0]  bpp;
    logic [31:0] shifted;
    logic [31:0] word;
    logic [7:0]  rep;
    logic [7:0]  pkt_after;
    logic [31:0] remain;

    always_comb
    begin
        pl_eff = (pixels_left_reg != 32'd0) ? pixels_left_reg :
                 (cfg.pixel_count == 32'd0) ? 32'd1 : cfg.pixel_count;
        bpp     = bytes_per_pixel(cfg.pixel_format);
        shifted = {24'd0, data_byte} << {byte_pos_reg, 3'b000};
        word      = {8'd0, pixel_bytes_reg} | shifted;
        rep       = 8'd1;
        pkt_after = packet_left_reg;
        remain    = pl_eff;

        expect_header_next = expect_header_reg;
        packet_is_run_next = packet_is_run_reg;
        packet_left_next   = packet_left_reg;
        byte_pos_next      = byte_pos_reg;
        pixel_bytes_next   = pixel_bytes_reg;
        pixels_left_next   = pixels_left_reg;
        issue              = '0;

        if (beat_en)
        begin
            pixels_left_next = pl_eff;
            if (cfg.rle_enable && expect_header_reg)
            begin
                packet_left_next   = {1'b0, data_byte[6:0]} + 8'd1;
                packet_is_run_next = data_byte[7];
                expect_header_next = 1'b0;
            end
            else if (({1'b0, byte_pos_reg} + 3'd1) < bpp)
            begin
                pixel_bytes_next = pixel_bytes_reg | shifted[23:0];
                byte_pos_next    = byte_pos_reg + 2'd1;
            end
            else
            begin
                byte_pos_next    = 2'd0;
                pixel_bytes_next = 24'd0;
                if (cfg.rle_enable)
                begin
                    if (packet_is_run_reg)
                    begin
                        rep       = (packet_left_reg == 8'd0) ? 8'd1 : packet_left_reg;
                        pkt_after = 8'd0;
                    end
                    else
                    begin
                        pkt_after = (packet_left_reg == 8'd0) ? 8'd0 :
                                    packet_left_reg - 8'd1;
                    end
                    packet_left_next = pkt_after;
                    if (pkt_after == 8'd0)
                    begin
                        expect_header_next = 1'b1;
                    end
                end
                // clip a run that overshoots the end of the image
                if ({24'd0, rep} > pl_eff)
                begin
                    rep = pl_eff[7:0];
                end
                remain           = pl_eff - {24'd0, rep};
                pixels_left_next = remain;

                issue.valid   = 1'b1;
                issue.fmt     = cfg.pixel_format;
                issue.word    = word;
                issue.pal_hit = (32'(word[7:0]) < 32'(PAL_ENTRIES));
                issue.rep     = rep;
                issue.done    = (remain == 32'd0);

                if (remain == 32'd0)
                begin
                    expect_header_next = 1'b1;
                    packet_is_run_next = 1'b0;
                    packet_left_next   = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            packet_left_reg   <= 8'd0;
            byte_pos_reg      <= 2'd0;
            pixel_bytes_reg   <= 24'd0;
            pixels_left_reg   <= 32'd0;
        end
        else
        begin
            expect_header_reg <= expect_header_next;
            packet_is_run_reg <= packet_is_run_next;
            packet_left_reg   <= packet_left_next;
            byte_pos_reg      <= byte_pos_next;
            pixel_bytes_reg   <= pixel_bytes_next;
            pixels_left_reg   <= pixels_left_next;
        end
    end

endmodule

/* sv/tga_px_stage.sv */
// Output stage: holds one pixel beat and converts it to RGBA, palette data arrives here.
module tga_px_stage
    import tga_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              pop,
    input  px_info_t          issue,
    input  logic [PAL_DW-1:0] pal_rdata,
    output logic              valid,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic [7:0]        alpha,
    output logic [7:0]        repeat_count,
    output logic              image_done
);

    logic     valid_reg, valid_next;
    px_info_t info_reg;
    logic [23:0] entry;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            info_reg <= issue;
        end
    end

    always_comb
    begin
        entry = info_reg.pal_hit ? 24'(pal_rdata) : 24'd0;
        red   = info_reg.word[23:16];
        green = info_reg.word[15:8];
        blue  = info_reg.word[7:0];
        alpha = 8'hFF;
        case (info_reg.fmt)
            FMT_INDEXED:
            begin
                red   = entry[23:16];
                green = entry[15:8];
                blue  = entry[7:0];
            end
            FMT_RGB16:
            begin
                red   = {info_reg.word[14:10], 3'b000};
                green = {info_reg.word[9:5], 3'b000};
                blue  = {info_reg.word[4:0], 3'b000};
            end
            FMT_BGRA32:
            begin
                alpha = info_reg.word[31:24];
            end
            FMT_GRAY8:
            begin
                red   = info_reg.word[7:0];
                green = 8'd0;
                blue  = 8'd0;
            end
            FMT_GRAY_ALPHA:
            begin
                red   = info_reg.word[7:0];
                green = info_reg.word[7:0];
                blue  = info_reg.word[7:0];
                alpha = info_reg.word[15:8];
            end
            default:
            begin
                red   = info_reg.word[23:16];
            end
        endcase
    end

    assign valid        = valid_reg;
    assign repeat_count = info_reg.rep;
    assign image_done   = info_reg.done;

endmodule
